@@ rtl/memory_lcd_frame_serializer_top_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef MEMORY_LCD_FRAME_SERIALIZER_TOP_MACROS_SVH
`define MEMORY_LCD_FRAME_SERIALIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MLFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mlfs_pkg.sv @@
package mlfs_pkg;

  localparam int CFG_AW      = 3;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic REG_BYTES_PER_LINE  = 1'b0;
  localparam logic REG_LINES_PER_FRAME = 1'b1;

  localparam logic [7:0] BPL_RESET = 8'd18;
  localparam logic [7:0] LPF_RESET = 8'd168;

  localparam logic [7:0] CMD_VCOM_HIGH = 8'hC0;
  localparam logic [7:0] CMD_VCOM_LOW  = 8'h80;
  localparam logic [7:0] FILL_BYTE     = 8'h00;

  // byte kinds
  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_ADDR    = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_TRAILER = 3'd3;
  localparam logic [2:0] KIND_DUMMY   = 3'd4;

  typedef struct packed {
    logic [7:0] bytes_per_line;
    logic [7:0] lines_per_frame;
  } mlfs_cfg_t;

  // One classified item: which bytes it sends and their contents.
  typedef struct packed {
    logic       has_cmd;
    logic       has_addr;
    logic       has_trl;
    logic       has_dummy;
    logic       vcom;
    logic [7:0] addr;
    logic [7:0] pix;
    logic [7:0] frames;
  } mlfs_job_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

@@ rtl/memory_lcd_frame_serializer_top.sv @@
// Memory LCD frame serializer. Takes pixel bytes in raster order on the in_
// channel and emits the SPI byte stream of a memory-LCD frame update on the
// out_ channel, one byte per result item. While idle, an item without
// in_frame_start is dropped; with it, the VCOM bit toggles and the command
// byte (0xC0 or 0x80) goes out, then the same item's pixel starts line 1.
// Each line sends its bit-reversed 1-based number, its data bytes and a 0x00
// trailer; after the last line a 0x00 dummy byte with out_select_release set
// ends the frame and out_frames_done advances. out_run_last marks the last
// byte caused by an input item.
// Rate: the output side delivers one byte per clock while a job is queued and
// out_stall is low; an item produces 1 byte for a plain data byte and up to 5
// at a frame start or end. The input side takes one item per clock while the
// two-entry job queue has room; dropped items take no queue slot. An accepted
// item is written into the job queue, and its first byte then goes into the
// output register. Registers: bytes_per_line at 0x0, lines_per_frame at 0x4;
// write them only while no item is in flight. A value lowered mid-frame ends
// the line or frame at the next item.
module memory_lcd_frame_serializer_top
  import mlfs_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // pixel items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_frame_start,
  input  logic [7:0]        in_pixel_byte,
  // SPI byte items
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_spi_byte,
  output logic [2:0]        out_byte_kind,
  output logic              out_select_release,
  output logic [7:0]        out_frames_done,
  output logic              out_run_last
);

  mlfs_cfg_t cfg;
  mlfs_job_t fr_job;   // classified item from the front end
  mlfs_job_t hd_job;   // queue head, worked off by the back end
  logic      take;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_nonempty;

  // Stall only on a full queue; the front end keeps all frame state.
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  mlfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end: updates line/position/VCOM/frame count as each non-dropped item
  // is taken and turns it into a job saying which of the five bytes it sends.
  mlfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .take        (take),
    .frame_start (in_frame_start),
    .pixel_byte  (in_pixel_byte),
    .push        (push),
    .job         (fr_job)
  );

  mlfs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_job   (fr_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rd_job   (hd_job)
  );

  // Back end: walks the head job's bytes in order into the output register.
  mlfs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (q_nonempty),
    .job                (hd_job),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_spi_byte       (out_spi_byte),
    .out_byte_kind      (out_byte_kind),
    .out_select_release (out_select_release),
    .out_frames_done    (out_frames_done),
    .out_run_last       (out_run_last)
  );

endmodule

@@ rtl/mlfs_regs.sv @@
module mlfs_regs
  import mlfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mlfs_cfg_t         cfg
);

  logic [7:0] bpl_r, bpl_nxt;
  logic [7:0] lpf_r, lpf_nxt;
  logic       wr_en;
  logic       sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = paddr[2];

  always_comb begin
    bpl_nxt = bpl_r;
    lpf_nxt = lpf_r;
    if (wr_en) begin
      unique case (sel)
        REG_BYTES_PER_LINE:  bpl_nxt = pwdata[7:0];
        REG_LINES_PER_FRAME: lpf_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r <= BPL_RESET;
      lpf_r <= LPF_RESET;
    end else begin
      bpl_r <= bpl_nxt;
      lpf_r <= lpf_nxt;
    end
  end

  always_comb begin
    unique case (sel)
      REG_BYTES_PER_LINE:  prdata = {24'd0, bpl_r};
      REG_LINES_PER_FRAME: prdata = {24'd0, lpf_r};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg.bytes_per_line  = bpl_r;
  assign cfg.lines_per_frame = lpf_r;

endmodule

@@ rtl/mlfs_front.sv @@
module mlfs_front
  import mlfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mlfs_cfg_t  cfg,
  input  logic       take,
  input  logic       frame_start,
  input  logic [7:0] pixel_byte,
  output logic       push,
  output mlfs_job_t  job
);

  logic       vcom_r, vcom_nxt;
  logic [7:0] line_r, line_nxt;
  logic [7:0] pos_r,  pos_nxt;
  logic [7:0] fc_r,   fc_nxt;

  logic       idle;
  logic [7:0] line_cur;
  logic [7:0] pos_cur;
  logic [7:0] pos_inc;
  logic       line_end;
  logic       frame_end;

  assign idle      = (line_r == 8'd0);
  assign line_cur  = idle ? 8'd1 : line_r;
  assign pos_cur   = idle ? 8'd0 : pos_r;
  assign pos_inc   = pos_cur + 8'd1;
  assign line_end  = (pos_inc >= cfg.bytes_per_line);
  assign frame_end = line_end && (line_cur >= cfg.lines_per_frame);

  // idle items without a frame request are dropped here
  assign push = take && !(idle && !frame_start);

  assign job.has_cmd   = idle;
  assign job.has_addr  = (pos_cur == 8'd0);
  assign job.has_trl   = line_end;
  assign job.has_dummy = frame_end;
  assign job.vcom      = vcom_nxt;
  assign job.addr      = flip8(line_cur);
  assign job.pix       = pixel_byte;
  assign job.frames    = fc_r;

  always_comb begin
    vcom_nxt = idle ? ~vcom_r : vcom_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    fc_nxt   = fc_r;
    if (push) begin
      pos_nxt = line_end ? 8'd0 : pos_inc;
      if (frame_end) begin
        line_nxt = 8'd0;
        fc_nxt   = fc_r + 8'd1;
      end else if (line_end) begin
        line_nxt = line_cur + 8'd1;
      end else begin
        line_nxt = line_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcom_r <= 1'b1;
      line_r <= 8'd0;
      pos_r  <= 8'd0;
      fc_r   <= 8'd0;
    end else begin
      if (push) begin
        vcom_r <= vcom_nxt;
      end
      line_r <= line_nxt;
      pos_r  <= pos_nxt;
      fc_r   <= fc_nxt;
    end
  end

endmodule

@@ rtl/mlfs_queue.sv @@
module mlfs_queue
  import mlfs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mlfs_job_t wr_job,
  input  logic      pop,
  output logic      full,
  output logic      nonempty,
  output mlfs_job_t rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mlfs_job_t         slot_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign nonempty = (cnt_r != '0);
  assign rd_job   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST_IDX) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_job;
    end
  end

endmodule

@@ rtl/mlfs_back.sv @@
module mlfs_back
  import mlfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  mlfs_job_t  job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_spi_byte,
  output logic [2:0] out_byte_kind,
  output logic       out_select_release,
  output logic [7:0] out_frames_done,
  output logic       out_run_last
);

  logic       started_r, started_nxt;
  logic [2:0] phase_r,   phase_nxt;
  logic       ov_r,      ov_nxt;
  logic [7:0] byte_r;
  logic [2:0] kind_r;
  logic       rel_r;
  logic [7:0] fd_r;
  logic       last_r;

  logic       emit;
  logic [2:0] kind_cur;
  logic [2:0] kind_next;
  logic [7:0] byte_cur;
  logic       last_cur;

  assign emit = job_valid && (!ov_r || !out_stall);
  assign pop  = emit && last_cur;

  always_comb begin
    if (started_r) begin
      kind_cur = phase_r;
    end else if (job.has_cmd) begin
      kind_cur = KIND_CMD;
    end else if (job.has_addr) begin
      kind_cur = KIND_ADDR;
    end else begin
      kind_cur = KIND_DATA;
    end
  end

  always_comb begin
    unique case (kind_cur)
      KIND_CMD: begin
        byte_cur  = job.vcom ? CMD_VCOM_HIGH : CMD_VCOM_LOW;
        last_cur  = 1'b0;
        kind_next = KIND_ADDR;
      end
      KIND_ADDR: begin
        byte_cur  = job.addr;
        last_cur  = 1'b0;
        kind_next = KIND_DATA;
      end
      KIND_DATA: begin
        byte_cur  = job.pix;
        last_cur  = !job.has_trl;
        kind_next = KIND_TRAILER;
      end
      KIND_TRAILER: begin
        byte_cur  = FILL_BYTE;
        last_cur  = !job.has_dummy;
        kind_next = KIND_DUMMY;
      end
      default: begin
        byte_cur  = FILL_BYTE;
        last_cur  = 1'b1;
        kind_next = KIND_DATA;
      end
    endcase
  end

  always_comb begin
    started_nxt = started_r;
    phase_nxt   = phase_r;
    if (emit) begin
      started_nxt = !last_cur;
      phase_nxt   = kind_next;
    end
    ov_nxt = emit ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      phase_r   <= KIND_CMD;
      ov_r      <= 1'b0;
    end else begin
      started_r <= started_nxt;
      phase_r   <= phase_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_cur;
      kind_r <= kind_cur;
      rel_r  <= (kind_cur == KIND_DUMMY);
      fd_r   <= (kind_cur == KIND_DUMMY) ? job.frames + 8'd1 : job.frames;
      last_r <= last_cur;
    end
  end

  assign out_valid          = ov_r;
  assign out_spi_byte       = byte_r;
  assign out_byte_kind      = kind_r;
  assign out_select_release = rel_r;
  assign out_frames_done    = fd_r;
  assign out_run_last       = last_r;

endmodule

@@ rtl/mlfs_checker.sv @@
`include "memory_lcd_frame_serializer_top_macros.svh"

module mlfs_checker
  import mlfs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_spi_byte,
  input logic [2:0] out_byte_kind,
  input logic       out_select_release,
  input logic       out_run_last
);

  `MLFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")

  `MLFS_ASSERT_NOW(a_rel_dummy, out_valid, out_select_release == (out_byte_kind == KIND_DUMMY), "select release not on dummy byte")

  `MLFS_ASSERT_NOW(a_dummy_last, out_valid && out_byte_kind == KIND_DUMMY, out_run_last && out_spi_byte == FILL_BYTE, "dummy byte malformed")

  `MLFS_ASSERT_NOW(a_cmd_code, out_valid && out_byte_kind == KIND_CMD, (out_spi_byte == CMD_VCOM_HIGH || out_spi_byte == CMD_VCOM_LOW) && !out_run_last, "bad command byte")

endmodule

bind memory_lcd_frame_serializer_top mlfs_checker u_mlfs_checker (.*);
